@@ src/skf_pkg.sv @@
// Shared types, microcode encodings and constants of the scalar Kalman filter.
`default_nettype none
package skf_pkg;

    localparam int unsigned PC_BITS   = 3;
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned CNT_BITS  = 5;

    typedef logic [PC_BITS-1:0]  t_pc;
    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DIV,
        OP_GAIN,
        OP_MUL_EST,
        OP_EST,
        OP_MUL_VAR,
        OP_VAR,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        CND_ALWAYS,
        CND_IN,
        CND_DIV,
        CND_OUT
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    localparam t_pc PC_IDLE    = 3'd0;
    localparam t_pc PC_DIV     = 3'd1;
    localparam t_pc PC_GAIN    = 3'd2;
    localparam t_pc PC_MUL_EST = 3'd3;
    localparam t_pc PC_EST     = 3'd4;
    localparam t_pc PC_MUL_VAR = 3'd5;
    localparam t_pc PC_VAR     = 3'd6;
    localparam t_pc PC_EMIT    = 3'd7;

    localparam int unsigned CFG_IDX_BITS = 1;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PROCESS_NOISE = 1'b0;
    localparam t_cfg_idx CFG_MEAS_NOISE    = 1'b1;

    localparam logic [15:0] Q_RESET = 16'd410;
    localparam logic [15:0] R_RESET = 16'd4096;

endpackage
`default_nettype wire

@@ src/skf_ucode.sv @@
// Control store: one microcode word per sequencer step.
`default_nettype none
module skf_ucode
    import skf_pkg::*;
(
    input  var t_pc    i_pc,
    output t_uword     o_word
);

    always_comb begin
        case (i_pc)
            PC_IDLE:    o_word = '{op: OP_LOAD,    cond: CND_IN,     target: PC_DIV};
            PC_DIV:     o_word = '{op: OP_DIV,     cond: CND_DIV,    target: PC_GAIN};
            PC_GAIN:    o_word = '{op: OP_GAIN,    cond: CND_ALWAYS, target: PC_MUL_EST};
            PC_MUL_EST: o_word = '{op: OP_MUL_EST, cond: CND_ALWAYS, target: PC_EST};
            PC_EST:     o_word = '{op: OP_EST,     cond: CND_ALWAYS, target: PC_MUL_VAR};
            PC_MUL_VAR: o_word = '{op: OP_MUL_VAR, cond: CND_ALWAYS, target: PC_VAR};
            PC_VAR:     o_word = '{op: OP_VAR,     cond: CND_ALWAYS, target: PC_EMIT};
            PC_EMIT:    o_word = '{op: OP_EMIT,    cond: CND_OUT,    target: PC_IDLE};
            default:    o_word = '{op: OP_LOAD,    cond: CND_IN,     target: PC_DIV};
        endcase
    end

endmodule
`default_nettype wire

@@ src/skf_seq.sv @@
// Microcode sequencer: step counter, divide loop counter and conditional jumps.
`default_nettype none
module skf_seq
    import skf_pkg::*;
(
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    input  var logic  i_in_valid,
    input  var logic  i_out_free,
    output logic      o_in_ready,
    output t_ctrl     o_ctrl
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_cnt   r_cnt;
    t_cnt   n_cnt;
    t_uword w_word;
    logic   w_met;

    skf_ucode u_ucode (
        .i_pc   (r_pc),
        .o_word (w_word)
    );

    always_comb begin
        case (w_word.cond)
            CND_ALWAYS: w_met = 1'b1;
            CND_IN:     w_met = i_in_valid;
            CND_DIV:    w_met = (r_cnt == CNT_BITS'(DIV_STEPS - 1));
            CND_OUT:    w_met = i_out_free;
            default:    w_met = 1'b1;
        endcase
    end

    always_comb begin
        n_pc  = w_met ? w_word.target : r_pc;
        n_cnt = r_cnt;
        if (w_word.cond == CND_DIV) begin
            n_cnt = w_met ? '0 : r_cnt + 1'b1;
        end
    end

    assign o_in_ready  = (w_word.cond == CND_IN);
    assign o_ctrl.op   = w_word.op;
    assign o_ctrl.fire = (w_word.cond == CND_DIV) ? 1'b1 : w_met;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

@@ src/skf_dp.sv @@
// Datapath: predict, restoring divider, shared multiplier and state update.
`default_nettype none
module skf_dp
    import skf_pkg::*;
(
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var t_ctrl       i_ctrl,
    input  var logic [15:0] i_sample,
    input  var logic [15:0] i_q,
    input  var logic [15:0] i_r,
    output logic [15:0]     o_estimate,
    output logic [15:0]     o_gain
);

    logic [15:0] r_est;
    logic [15:0] n_est;
    logic [15:0] r_ev;
    logic [15:0] n_ev;
    logic [15:0] r_smp;
    logic [15:0] r_pp;
    logic [16:0] r_den;
    logic [17:0] r_rem;
    logic [16:0] r_quo;
    logic [15:0] r_k;
    logic [15:0] r_mag;
    logic        r_neg;
    logic [32:0] r_prod;

    logic [16:0] w_sum;
    logic [15:0] w_pp;
    logic [16:0] w_den;
    logic        w_ge;
    logic [17:0] w_rem_sub;
    logic [16:0] w_mul_a;
    logic [15:0] w_mul_b;
    logic [32:0] w_prod;
    logic [32:0] w_rnd;
    logic [16:0] w_step;
    logic [17:0] w_up;
    logic [16:0] w_dn;
    logic [15:0] w_k;
    logic        w_do;

    assign w_do = i_ctrl.fire;

    always_comb begin
        w_sum     = {1'b0, r_ev} + {1'b0, i_q};
        w_pp      = w_sum[16] ? 16'hFFFF : w_sum[15:0];
        w_den     = {1'b0, w_pp} + {1'b0, i_r};
        w_ge      = (r_rem >= {1'b0, r_den});
        w_rem_sub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;
        if (r_den == '0) begin
            w_k = '0;
        end else if (r_quo[16]) begin
            w_k = 16'hFFFF;
        end else begin
            w_k = r_quo[15:0];
        end
        w_mul_a = (i_ctrl.op == OP_MUL_VAR) ? (17'h10000 - {1'b0, r_k}) : {1'b0, r_k};
        w_mul_b = (i_ctrl.op == OP_MUL_VAR) ? r_pp : r_mag;
        w_prod  = w_mul_a * w_mul_b;
        w_rnd   = r_prod + 33'd32768;
        w_step  = w_rnd[32:16];
        w_up    = {2'b00, r_est} + {1'b0, w_step};
        w_dn    = {1'b0, r_est} - w_step;
        if (r_neg) begin
            n_est = (w_step > {1'b0, r_est}) ? 16'h0000 : w_dn[15:0];
        end else begin
            n_est = (w_up > 18'h0FFFF) ? 16'hFFFF : w_up[15:0];
        end
        n_ev = w_step[16] ? 16'hFFFF : w_step[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_ev  <= '0;
        end else if (w_do) begin
            if (i_ctrl.op == OP_EST) begin
                r_est <= n_est;
            end
            if (i_ctrl.op == OP_VAR) begin
                r_ev <= n_ev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do) begin
            case (i_ctrl.op)
                OP_LOAD: begin
                    r_smp <= i_sample;
                    r_pp  <= w_pp;
                    r_den <= w_den;
                    r_rem <= {2'b00, w_pp};
                    r_quo <= '0;
                end
                OP_DIV: begin
                    r_rem <= {w_rem_sub[16:0], 1'b0};
                    r_quo <= {r_quo[15:0], w_ge};
                end
                OP_GAIN: begin
                    r_k   <= w_k;
                    r_neg <= (r_smp < r_est);
                    r_mag <= (r_smp < r_est) ? (r_est - r_smp) : (r_smp - r_est);
                end
                OP_MUL_EST: r_prod <= w_prod;
                OP_MUL_VAR: r_prod <= w_prod;
                default: begin
                end
            endcase
        end
    end

    assign o_estimate = r_est;
    assign o_gain     = r_k;

endmodule
`default_nettype wire

@@ src/scalar_kalman_filter_top.sv @@
// Top level of the scalar Kalman filter: ports, registers, result buffer.
//
// Input stream s_axis: one sensor sample per word. Output stream m_axis: one
// word per sample with the new estimate (Q8.8 by default) and the gain used.
// The configuration channel writes process noise (index 0) and measurement
// noise (index 1), both Q4.12; it is always ready. The user must write it only
// while the filter is idle; the block itself does not enforce this.
// Each sample goes through these steps from acceptance to the result entering
// the output register: the load step at acceptance, 17 steps of the
// bit-serial divider that forms the gain, the gain step, two multiply and
// update pairs and the emit step. One sample is in flight at a time and the
// next one is accepted the cycle after the emit step.
// The next sample is accepted as soon as the result sits in the output
// register, even while the receiver stalls. If the receiver still holds
// the previous word at the emit step, the sequencer waits there.
// Reset (synchronous, active low) clears estimate and variance to zero,
// restores the default noise values and empties the output register.
`default_nettype none
module scalar_kalman_filter_top
    import skf_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 8
) (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    input  var logic                 s_axis_tvalid,
    output logic                     s_axis_tready,
    // sample
    input  var logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  var logic                 m_axis_tready,
    // estimate_out [15:0], gain_out [31:16]
    output logic [31:0]              m_axis_tdata,
    input  var logic                 i_cfg_valid,
    output logic                     o_cfg_ready,
    input  var t_cfg_idx             i_cfg_index,
    input  var logic [15:0]          i_cfg_data
);

    logic [15:0] r_q;
    logic [15:0] r_r;
    logic        r_out_valid;
    logic [15:0] r_out_est;
    logic [15:0] r_out_gain;
    logic [15:0] w_sample;
    logic        w_out_free;
    logic        w_accept;
    logic        w_emit;
    logic [15:0] w_est;
    logic [15:0] w_gain;
    t_ctrl       w_ctrl;

    assign w_sample   = 16'(s_axis_tdata[SAMPLE_BITS-1:0]) << (16 - SAMPLE_BITS);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_emit     = w_ctrl.fire && (w_ctrl.op == OP_EMIT);
    assign o_cfg_ready = 1'b1;

    skf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    skf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_sample   (w_sample),
        .i_q        (r_q),
        .i_r        (r_r),
        .o_estimate (w_est),
        .o_gain     (w_gain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q         <= Q_RESET;
            r_r         <= R_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE: r_q <= i_cfg_data;
                    CFG_MEAS_NOISE:    r_r <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_est  <= w_est;
            r_out_gain <= w_gain;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_gain, r_out_est};

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("sample accepted while another is in flight");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##23 (w_ctrl.op == OP_EMIT))
        else $error("emit step not reached 23 cycles after acceptance");

    a_emit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> m_axis_tvalid)
        else $error("emitted word missing from output register");

endmodule
`default_nettype wire

@@ tb/scalar_kalman_filter_top_tb.sv @@
// Self-checking testbench of the scalar Kalman filter: stream stimulus, predictor, checker.
module scalar_kalman_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import skf_pkg::*;

    typedef struct packed {
        logic [15:0] gain;
        logic [15:0] estimate;
    } t_kf_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_PROCESS_NOISE;
    logic [15:0] i_cfg_data = '0;

    logic [15:0] est_state = '0;
    logic [15:0] var_state = '0;
    logic [15:0] q_noise = Q_RESET;
    logic [15:0] r_noise = R_RESET;

    t_kf_word    expected_words[$];
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          err_count = 0;
    int          samples_sent = 0;
    int          words_checked = 0;
    int          noise_settings = 0;

    scalar_kalman_filter_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_kf_word kalman_update(logic [7:0] sample);
        longint unsigned pp, den, k, mag, stp, aligned, nv;
        longint signed   nxt;
        t_kf_word        w;
        pp = longint'(var_state) + longint'(q_noise);
        if (pp > 65535) pp = 65535;
        den = pp + longint'(r_noise);
        if (den == 0) begin
            k = 0;
        end else begin
            k = (pp << 16) / den;
            if (k > 65535) k = 65535;
        end
        aligned = longint'(sample) << 8;
        if (aligned >= longint'(est_state)) begin
            mag = aligned - longint'(est_state);
            stp = (k * mag + 32768) >> 16;
            nxt = longint'(est_state) + longint'(stp);
        end else begin
            mag = longint'(est_state) - aligned;
            stp = (k * mag + 32768) >> 16;
            nxt = longint'(est_state) - longint'(stp);
        end
        if (nxt < 0) nxt = 0;
        if (nxt > 65535) nxt = 65535;
        est_state = nxt[15:0];
        nv = (pp * (65536 - k) + 32768) >> 16;
        if (nv > 65535) nv = 65535;
        var_state = nv[15:0];
        w.estimate = est_state;
        w.gain = k[15:0];
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        t_kf_word want;
        t_kf_word got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", got, 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (got.estimate !== want.estimate)
                    report_mismatch("estimate", 32'(got.estimate), 32'(want.estimate));
                if (got.gain !== want.gain)
                    report_mismatch("gain", 32'(got.gain), 32'(want.gain));
                words_checked++;
            end
        end
    end

    task automatic send_sample(logic [7:0] sample);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_words.push_back(kalman_update(sample));
        samples_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic write_noise(t_cfg_idx idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PROCESS_NOISE: q_noise = value;
            CFG_MEAS_NOISE:    r_noise = value;
            default: ;
        endcase
    endtask

    task automatic config_noise(logic [15:0] q, logic [15:0] r);
        drain_results();
        write_noise(CFG_PROCESS_NOISE, q);
        write_noise(CFG_MEAS_NOISE, r);
        i_cfg_valid <= 1'b0;
        noise_settings++;
    endtask

    function automatic logic [15:0] pick_noise(bit meas);
        case ($urandom_range(4))
            0:       return meas ? 16'd1 : 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(meas ? 1 : 0, 65535));
            3:       return 16'($urandom_range(1, 2000));
            default: return 16'($urandom_range(2048, 8192));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd128);
    endtask

    task automatic test_zero_noise();
        config_noise(16'd0, 16'd0);
        send_sample(8'd200);
        send_sample(8'd255);
        send_sample(8'd0);
        config_noise(16'd4096, 16'd0);
        send_sample(8'd0);
        send_sample(8'd255);
    endtask

    task automatic test_noise_extremes();
        config_noise(16'hFFFF, 16'd1);
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd128);
        config_noise(16'hFFFF, 16'hFFFF);
        send_sample(8'd255);
        send_sample(8'd0);
        config_noise(16'd0, 16'hFFFF);
        send_sample(8'd1);
        send_sample(8'd254);
        send_sample(8'd170);
        send_sample(8'd85);
    endtask

    task automatic test_default_noise();
        config_noise(Q_RESET, R_RESET);
        repeat (2) begin
            send_sample(8'd0);
            send_sample(8'd255);
        end
    endtask

    task automatic test_random_phase(int src_pct, int sink_pct, int n_items);
        int         sent;
        int         seg;
        int         mode;
        int         v;
        logic [7:0] level;
        logic [7:0] sample;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent  = 0;
        level = 8'($urandom_range(255));
        while (sent < n_items) begin
            config_noise(pick_noise(1'b0), pick_noise(1'b1));
            seg  = $urandom_range(30, 120);
            if (seg > n_items - sent) seg = n_items - sent;
            mode = $urandom_range(3);
            repeat (seg) begin
                case (mode)
                    0: sample = 8'($urandom_range(255));
                    1: begin
                        v = int'(level) + $urandom_range(16) - 8;
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                        sample = 8'(v);
                        if ($urandom_range(31) == 0) level = 8'($urandom_range(255));
                    end
                    2: sample = $urandom_range(1) ? 8'd255 : 8'd0;
                    default: begin
                        level  = level + 8'($urandom_range(3));
                        sample = level;
                    end
                endcase
                send_sample(sample);
                sent++;
                if ($urandom_range(199) == 0) drain_results();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle_pct  = 6;
        sink_idle_pct = 48;
        test_reset_defaults();
        test_zero_noise();
        test_noise_extremes();
        test_default_noise();
        test_random_phase(6, 48, 600);
        test_random_phase(48, 6, 600);
        test_random_phase(0, 0, 600);
        drain_results();
        repeat (48) @(posedge i_clk);
        $display("Covered %0d samples and %0d checked words over %0d noise settings,",
                 samples_sent, words_checked, noise_settings);
        $display("including zero noise, saturated noise and three idle mixes.");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
